### hw/rtl/pets_pkg.sv
// Package: constants and codes shared by the task scheduler files.
package pets_pkg;

  localparam int MaxTasksDefault = 16;

  localparam logic [3:0] CMD_INIT      = 4'd0;
  localparam logic [3:0] CMD_START     = 4'd1;
  localparam logic [3:0] CMD_STOP      = 4'd2;
  localparam logic [3:0] CMD_SET_EVENT = 4'd3;
  localparam logic [3:0] CMD_TASK_DONE = 4'd4;
  localparam logic [3:0] CMD_LOCK      = 4'd5;
  localparam logic [3:0] CMD_UNLOCK    = 4'd6;
  localparam logic [3:0] CMD_SWITCH    = 4'd7;
  localparam logic [3:0] CMD_QUERY     = 4'd8;

  localparam logic [3:0] RC_OK          = 4'd0;
  localparam logic [3:0] RC_NO_TASKS    = 4'd1;
  localparam logic [3:0] RC_RUNNING     = 4'd2;
  localparam logic [3:0] RC_TOO_MANY    = 4'd3;
  localparam logic [3:0] RC_NOT_INIT    = 4'd4;
  localparam logic [3:0] RC_NOT_RUNNING = 4'd5;
  localparam logic [3:0] RC_LOCK_FULL   = 4'd6;
  localparam logic [3:0] RC_NOT_LOCKED  = 4'd7;
  localparam logic [3:0] RC_BAD_TASK    = 4'd8;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_WAITING = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [1:0] MODE_UNINIT   = 2'd0;
  localparam logic [1:0] MODE_INIT     = 2'd1;
  localparam logic [1:0] MODE_RUNNING  = 2'd2;
  localparam logic [1:0] MODE_SHUTDOWN = 2'd3;

  localparam logic [7:0] NO_TASK  = 8'hFF;
  localparam logic [7:0] CNT_MAX  = 8'hFF;

  localparam logic CFG_TASK_COUNT = 1'b0;
  localparam logic CFG_QUEUE_MASK = 1'b1;

endpackage

### hw/rtl/priority_event_task_scheduler.sv
// Top level: fixed-priority preemptive task scheduler bookkeeping.
// Flow: each accepted command is executed and then reported as a result beat;
//   start sweeps MAX_TASKS entries and then scans before reporting; task done,
//   and unlock when it releases the last lock, scan down from the top first.
// Throughput: one command at a time; in_stall stays high until the result beat
//   has been taken.
// Reset (rst, synchronous): tables, flags, mode and control state cleared; command and result registers are not reset.
module priority_event_task_scheduler #(
  parameter int MAX_TASKS = pets_pkg::MaxTasksDefault
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  command,
  input  logic [7:0]  task_req,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  result_code,
  output logic        switch_request,
  output logic        fresh_start,
  output logic [7:0]  current_task,
  output logic [3:0]  waiting_task,
  output logic [1:0]  task_state,
  output logic [7:0]  pending_events,
  output logic [31:0] switches_done,
  output logic [7:0]  lock_level,
  output logic [1:0]  run_mode,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(MAX_TASKS);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_CLEAR, S_SCAN, S_REPORT, S_OUT} state_t;

  state_t      state;
  logic [3:0]  cmd;
  logic [7:0]  treq;
  logic [3:0]  rc;
  logic        sw;
  logic        fresh;
  logic        scan_cmp; // compare next level against running after the scan

  // task tables, held in flops (small and written at chosen addresses)
  logic [1:0]  status_tab [MAX_TASKS];
  logic [7:0]  event_tab  [MAX_TASKS];
  logic [31:0] switch_tab [MAX_TASKS];
  logic [MAX_TASKS-1:0] started;

  logic [7:0]  running_level;
  logic [IW-1:0] next_level;
  logic [7:0]  lock_count;
  logic [1:0]  mode;
  logic [7:0]  tasks_in_use;
  logic [7:0]  task_count;
  logic [15:0] queue_mask;
  logic [IW-1:0] idx;

  // the addressed task
  logic          valid_t;
  logic [IW-1:0] ti;
  logic          queues_t;
  logic [IW-1:0] nl_ti;
  logic [7:0]    ev_t;
  logic [1:0]    st_t;
  logic          rl_ok;
  logic [IW-1:0] rl_i;

  assign valid_t  = ({24'd0, treq} < 32'(MAX_TASKS));
  assign ti       = treq[IW-1:0];
  assign queues_t = (treq < 8'd16) && queue_mask[treq[3:0]];
  assign ev_t     = event_tab[ti];
  assign st_t     = status_tab[ti];
  assign rl_ok    = (running_level < tasks_in_use) &&
                    ({24'd0, running_level} < 32'(MAX_TASKS));
  assign rl_i     = running_level[IW-1:0];
  assign nl_ti    = ti;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      running_level <= 8'd0;
      next_level    <= '0;
      lock_count    <= 8'd0;
      mode          <= pets_pkg::MODE_UNINIT;
      tasks_in_use  <= 8'd0;
      task_count    <= 8'd0;
      queue_mask    <= 16'd0;
      started       <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        status_tab[i] <= pets_pkg::ST_READY;
        event_tab[i]  <= 8'd0;
        switch_tab[i] <= 32'd0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == pets_pkg::CFG_TASK_COUNT) task_count <= cfg_data[7:0];
            else queue_mask <= cfg_data;
          end
          if (in_valid) begin
            cmd      <= command;
            treq     <= task_req;
            rc       <= pets_pkg::RC_OK;
            sw       <= 1'b0;
            fresh    <= 1'b0;
            scan_cmp <= 1'b0;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_REPORT;
          priority case (cmd)
            pets_pkg::CMD_INIT: begin
              if (task_count == 8'd0) rc <= pets_pkg::RC_NO_TASKS;
              else if (mode == pets_pkg::MODE_RUNNING) rc <= pets_pkg::RC_RUNNING;
              else if ({24'd0, task_count} > 32'(MAX_TASKS)) rc <= pets_pkg::RC_TOO_MANY;
              else begin
                tasks_in_use <= task_count;
                mode         <= pets_pkg::MODE_INIT;
              end
            end
            pets_pkg::CMD_START: begin
              if (mode == pets_pkg::MODE_UNINIT) rc <= pets_pkg::RC_NOT_INIT;
              else if (mode != pets_pkg::MODE_INIT) rc <= pets_pkg::RC_RUNNING;
              else begin
                idx   <= '0;
                state <= S_CLEAR;
              end
            end
            pets_pkg::CMD_STOP: begin
              if (mode == pets_pkg::MODE_RUNNING) begin
                mode <= pets_pkg::MODE_SHUTDOWN;
                sw   <= 1'b1;
              end else rc <= pets_pkg::RC_NOT_RUNNING;
            end
            pets_pkg::CMD_SET_EVENT: begin
              if (!valid_t) rc <= pets_pkg::RC_BAD_TASK;
              else if (queues_t && ev_t != 8'd0) begin
                if (ev_t != pets_pkg::CNT_MAX) event_tab[ti] <= ev_t + 8'd1;
                // status unchanged: check for preemption against stored status
                if (ti > next_level && st_t == pets_pkg::ST_WAITING) begin
                  next_level <= nl_ti;
                  if (lock_count == 8'd0) sw <= 1'b1;
                end
              end else begin
                event_tab[ti] <= 8'd1;
                if (st_t == pets_pkg::ST_READY) status_tab[ti] <= pets_pkg::ST_WAITING;
                if (ti > next_level &&
                    (st_t == pets_pkg::ST_READY || st_t == pets_pkg::ST_WAITING)) begin
                  next_level <= nl_ti;
                  if (lock_count == 8'd0) sw <= 1'b1;
                end
              end
            end
            pets_pkg::CMD_TASK_DONE: begin
              if (!valid_t) rc <= pets_pkg::RC_BAD_TASK;
              else begin
                started[ti] <= 1'b0;
                if (ti != '0) begin
                  if (queues_t && ev_t > 8'd1) event_tab[ti] <= ev_t - 8'd1;
                  else event_tab[ti] <= 8'd0;
                end
                sw    <= 1'b1;
                idx   <= IW'(MAX_TASKS - 1);
                state <= S_SCAN;
              end
            end
            pets_pkg::CMD_LOCK: begin
              if (lock_count != pets_pkg::CNT_MAX) lock_count <= lock_count + 8'd1;
              else rc <= pets_pkg::RC_LOCK_FULL;
            end
            pets_pkg::CMD_UNLOCK: begin
              if (lock_count == 8'd1) begin
                lock_count <= 8'd0;
                scan_cmp   <= 1'b1;
                idx        <= IW'(MAX_TASKS - 1);
                state      <= S_SCAN;
              end else if (lock_count > 8'd1) lock_count <= lock_count - 8'd1;
              else rc <= pets_pkg::RC_NOT_LOCKED;
            end
            pets_pkg::CMD_SWITCH: begin
              if (mode == pets_pkg::MODE_SHUTDOWN) mode <= pets_pkg::MODE_INIT;
              else if (lock_count == 8'd0 &&
                       (running_level != {{(8-IW){1'b0}}, next_level} ||
                        !started[next_level])) begin
                if (rl_ok) begin
                  if (started[rl_i] || event_tab[rl_i] != 8'd0)
                    status_tab[rl_i] <= pets_pkg::ST_WAITING;
                  else status_tab[rl_i] <= pets_pkg::ST_READY;
                end
                running_level          <= {{(8-IW){1'b0}}, next_level};
                status_tab[next_level] <= pets_pkg::ST_RUNNING;
                switch_tab[next_level] <= switch_tab[next_level] + 32'd1;
                if (!started[next_level]) begin
                  fresh               <= 1'b1;
                  started[next_level] <= 1'b1;
                end
              end
            end
            default: begin
              if (cmd == pets_pkg::CMD_QUERY && !valid_t) rc <= pets_pkg::RC_BAD_TASK;
            end
          endcase
        end
        S_CLEAR: begin
          // sweep the tasks in use, one per cycle; idle task ends up waiting
          if ({{(8-IW){1'b0}}, idx} < tasks_in_use) begin
            status_tab[idx] <= pets_pkg::ST_READY;
            event_tab[idx]  <= 8'd0;
            switch_tab[idx] <= 32'd0;
            started[idx]    <= 1'b0;
          end
          if (idx == IW'(MAX_TASKS - 1)) begin
            running_level <= pets_pkg::NO_TASK;
            mode          <= pets_pkg::MODE_RUNNING;
            lock_count    <= 8'd0;
            event_tab[0]  <= 8'd1;
            if (status_tab[0] == pets_pkg::ST_READY ||
                tasks_in_use != 8'd0) status_tab[0] <= pets_pkg::ST_WAITING;
            scan_cmp <= 1'b1;
            idx      <= IW'(MAX_TASKS - 1);
            state    <= S_SCAN;
          end else idx <= idx + 1'b1;
        end
        S_SCAN: begin
          // walk down from the top; stop at the first level with events, or at level 0
          if (event_tab[idx] != 8'd0 || idx == '0) begin
            next_level <= idx;
            if (scan_cmp && running_level != {{(8-IW){1'b0}}, idx}) sw <= 1'b1;
            state <= S_REPORT;
          end else idx <= idx - 1'b1;
        end
        S_REPORT: begin
          result_code    <= rc;
          switch_request <= sw;
          fresh_start    <= fresh;
          current_task   <= running_level;
          waiting_task   <= 4'(next_level);
          task_state     <= valid_t ? st_t : pets_pkg::ST_UNKNOWN;
          pending_events <= valid_t ? ev_t : 8'd0;
          switches_done  <= valid_t ? switch_tab[ti] : 32'd0;
          lock_level     <= lock_count;
          run_mode       <= mode;
          out_valid      <= 1'b1;
          state          <= S_OUT;
        end
        S_OUT: begin
          // hold the result beat until taken
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/pets_checker.sv
// Checker: port-level properties of the task scheduler, bound to the top level.
module pets_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] result_code,
  input logic       cfg_ready
);

  ap_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("command taken while a result waits");

  ap_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");

  ap_rc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_code <= 4'd8)) else $error("result code out of range");

  ap_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall) else $error("configuration open while busy");

endmodule

bind priority_event_task_scheduler pets_checker u_pets_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .result_code(result_code),
  .cfg_ready(cfg_ready)
);

### bench/tb.sv
// Self-checking testbench for the priority event task scheduler.
`timescale 1ns / 1ps

module tb;

  localparam int NTASK = 16;
  // Start sweeps and then scans the task tables before its result beat.
  localparam int SETTLE = 2 * NTASK + 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  command = pets_pkg::CMD_QUERY;
  logic [7:0]  task_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  result_code;
  logic        switch_request;
  logic        fresh_start;
  logic [7:0]  current_task;
  logic [3:0]  waiting_task;
  logic [1:0]  task_state;
  logic [7:0]  pending_events;
  logic [31:0] switches_done;
  logic [7:0]  lock_level;
  logic [1:0]  run_mode;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = pets_pkg::CFG_TASK_COUNT;
  logic [15:0] cfg_data = '0;

  priority_event_task_scheduler DUT (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    logic [3:0]  rc;
    logic        sw;
    logic        fresh;
    logic [7:0]  cur;
    logic [3:0]  waiting;
    logic [1:0]  state;
    logic [7:0]  events;
    logic [31:0] switches;
    logic [7:0]  lock;
    logic [1:0]  mode;
  } sched_result_t;

  typedef struct packed {
    logic        do_cfg;
    logic [7:0]  cfg_count;
    logic [15:0] cfg_mask;
    logic [3:0]  cmd;
    logic [7:0]  tsk;
    logic        typed;
    logic [3:0]  rc;
  } stim_row_t;

  sched_result_t expected_results[$];

  // Scheduler mirror
  logic [1:0]  m_status [NTASK];
  logic [7:0]  m_events [NTASK];
  logic [31:0] m_switches [NTASK];
  logic [15:0] m_started;
  logic [7:0]  m_running;
  logic [3:0]  m_next;
  logic [7:0]  m_lock;
  logic [1:0]  m_mode;
  logic [7:0]  m_in_use;
  logic [7:0]  m_task_count;
  logic [15:0] m_queue_mask;

  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int rx_hold = 0;

  function automatic logic [3:0] highest_pending();
    for (int i = NTASK - 1; i >= 0; i--)
      if (m_events[i] != 0) return 4'(i);
    return 4'd0;
  endfunction

  function automatic bit counts_events(logic [7:0] t);
    return t < 16 && m_queue_mask[t[3:0]];
  endfunction

  // Advance the mirror by one command and return the beat it should produce.
  function automatic sched_result_t sched_predict(logic [3:0] cmd, logic [7:0] t);
    sched_result_t r;
    bit ok_task;
    logic [3:0] ti;
    ok_task = t < NTASK;
    ti = t[3:0];
    r.rc = pets_pkg::RC_OK;
    r.sw = 1'b0;
    r.fresh = 1'b0;
    case (cmd)
      pets_pkg::CMD_INIT: begin
        if (m_task_count == 0) r.rc = pets_pkg::RC_NO_TASKS;
        else if (m_mode == pets_pkg::MODE_RUNNING) r.rc = pets_pkg::RC_RUNNING;
        else if (m_task_count > NTASK) r.rc = pets_pkg::RC_TOO_MANY;
        else begin
          m_in_use = m_task_count;
          m_mode = pets_pkg::MODE_INIT;
        end
      end
      pets_pkg::CMD_START: begin
        if (m_mode == pets_pkg::MODE_UNINIT) r.rc = pets_pkg::RC_NOT_INIT;
        else if (m_mode != pets_pkg::MODE_INIT) r.rc = pets_pkg::RC_RUNNING;
        else begin
          for (int i = 0; i < NTASK; i++)
            if (i < m_in_use) begin
              m_status[i] = pets_pkg::ST_READY;
              m_events[i] = '0;
              m_switches[i] = '0;
              m_started[i] = 1'b0;
            end
          m_events[0] = 8'd1;
          if (m_status[0] == pets_pkg::ST_READY) m_status[0] = pets_pkg::ST_WAITING;
          m_running = pets_pkg::NO_TASK;
          m_mode = pets_pkg::MODE_RUNNING;
          m_lock = '0;
          m_next = highest_pending();
          if ({4'd0, m_next} != m_running) r.sw = 1'b1;
        end
      end
      pets_pkg::CMD_STOP: begin
        if (m_mode == pets_pkg::MODE_RUNNING) begin
          m_mode = pets_pkg::MODE_SHUTDOWN;
          r.sw = 1'b1;
        end else r.rc = pets_pkg::RC_NOT_RUNNING;
      end
      pets_pkg::CMD_SET_EVENT: begin
        if (!ok_task) r.rc = pets_pkg::RC_BAD_TASK;
        else begin
          if (counts_events(t) && m_events[ti] > 0) begin
            if (m_events[ti] < pets_pkg::CNT_MAX) m_events[ti]++;
          end else begin
            m_events[ti] = 8'd1;
            if (m_status[ti] == pets_pkg::ST_READY) m_status[ti] = pets_pkg::ST_WAITING;
          end
          if (ti > m_next && m_status[ti] == pets_pkg::ST_WAITING) begin
            m_next = ti;
            if (m_lock == 0) r.sw = 1'b1;
          end
        end
      end
      pets_pkg::CMD_TASK_DONE: begin
        if (!ok_task) r.rc = pets_pkg::RC_BAD_TASK;
        else begin
          m_started[ti] = 1'b0;
          // the idle task keeps its events
          if (ti != 0) begin
            if (counts_events(t) && m_events[ti] > 1) m_events[ti]--;
            else m_events[ti] = '0;
          end
          m_next = highest_pending();
          r.sw = 1'b1;
        end
      end
      pets_pkg::CMD_LOCK: begin
        if (m_lock < pets_pkg::CNT_MAX) m_lock++;
        else r.rc = pets_pkg::RC_LOCK_FULL;
      end
      pets_pkg::CMD_UNLOCK: begin
        if (m_lock == 1) begin
          m_lock = '0;
          m_next = highest_pending();
          if ({4'd0, m_next} != m_running) r.sw = 1'b1;
        end else if (m_lock > 1) m_lock--;
        else r.rc = pets_pkg::RC_NOT_LOCKED;
      end
      pets_pkg::CMD_SWITCH: begin
        if (m_mode == pets_pkg::MODE_SHUTDOWN) m_mode = pets_pkg::MODE_INIT;
        else if (m_lock == 0 &&
                 ({4'd0, m_next} != m_running || !m_started[m_next])) begin
          if (m_running < m_in_use && m_running < NTASK) begin
            if (m_started[m_running[3:0]])
              m_status[m_running[3:0]] = pets_pkg::ST_WAITING;
            else
              m_status[m_running[3:0]] = m_events[m_running[3:0]] > 0 ?
                                         pets_pkg::ST_WAITING : pets_pkg::ST_READY;
          end
          m_running = {4'd0, m_next};
          m_status[m_next] = pets_pkg::ST_RUNNING;
          m_switches[m_next] = m_switches[m_next] + 32'd1;
          if (!m_started[m_next]) begin
            r.fresh = 1'b1;
            m_started[m_next] = 1'b1;
          end
        end
      end
      pets_pkg::CMD_QUERY: if (!ok_task) r.rc = pets_pkg::RC_BAD_TASK;
      default: ;
    endcase
    r.cur = m_running;
    r.waiting = m_next;
    r.state = ok_task ? m_status[ti] : pets_pkg::ST_UNKNOWN;
    r.events = ok_task ? m_events[ti] : 8'd0;
    r.switches = ok_task ? m_switches[ti] : 32'd0;
    r.lock = m_lock;
    r.mode = m_mode;
    return r;
  endfunction

  // Receiver: stall at random at the falling edge, or hold off when asked.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endfunction

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("result_code", e.rc, result_code);
        check_field("switch_request", e.sw, switch_request);
        check_field("fresh_start", e.fresh, fresh_start);
        check_field("current_task", e.cur, current_task);
        check_field("waiting_task", e.waiting, waiting_task);
        check_field("task_state", e.state, task_state);
        check_field("pending_events", e.events, pending_events);
        check_field("switches_done", e.switches, switches_done);
        check_field("lock_level", e.lock, lock_level);
        check_field("run_mode", e.mode, run_mode);
      end
    end
  end

  // Offer one command beat and hold it until accepted; typed rows override
  // the predicted result code.
  task automatic send_cmd(logic [3:0] cmd, logic [7:0] t, bit typed = 0,
                          logic [3:0] rc = pets_pkg::RC_OK);
    sched_result_t r;
    int gap;
    command  = cmd;
    task_req = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = sched_predict(cmd, t);
    if (typed) r.rc = rc;
    expected_results.push_back(r);
    items_sent++;
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drain all results and let any scan finish before touching registers.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pets_pkg::CFG_TASK_COUNT) m_task_count = data[7:0];
    else m_queue_mask = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [7:0] count, logic [15:0] mask);
    settle();
    // upper byte of the count register is ignored, so fill it at random
    write_reg(pets_pkg::CFG_TASK_COUNT, {8'($urandom), count});
    write_reg(pets_pkg::CFG_QUEUE_MASK, mask);
  endtask

  function automatic logic [7:0] pick_task();
    if ($urandom_range(99) < 8) return 8'($urandom);
    if ($urandom_range(99) < 50) return 8'($urandom_range(8, 15));
    return 8'($urandom_range(0, 15));
  endfunction

  // Mostly events, switches and completions, a little lock traffic and
  // the odd mode change or unused code.
  task automatic random_cmd();
    int p;
    p = $urandom_range(999);
    if (p < 300) send_cmd(pets_pkg::CMD_SET_EVENT, pick_task());
    else if (p < 470) send_cmd(pets_pkg::CMD_SWITCH, pick_task());
    else if (p < 620) send_cmd(pets_pkg::CMD_TASK_DONE, pick_task());
    else if (p < 700) send_cmd(pets_pkg::CMD_LOCK, pick_task());
    else if (p < 790) send_cmd(pets_pkg::CMD_UNLOCK, pick_task());
    else if (p < 900) send_cmd(pets_pkg::CMD_QUERY, pick_task());
    else if (p < 930) send_cmd(pets_pkg::CMD_INIT, pick_task());
    else if (p < 960) send_cmd(pets_pkg::CMD_START, pick_task());
    else if (p < 985) send_cmd(pets_pkg::CMD_STOP, pick_task());
    else send_cmd(4'($urandom_range(9, 15)), pick_task());
  endtask

  stim_row_t directed_rows [25];

  initial begin
    // reset state of the mirror
    for (int i = 0; i < NTASK; i++) begin
      m_status[i] = pets_pkg::ST_READY;
      m_events[i] = '0;
      m_switches[i] = '0;
    end
    m_started = '0;
    m_running = '0;
    m_next = '0;
    m_lock = '0;
    m_mode = pets_pkg::MODE_UNINIT;
    m_in_use = '0;
    m_task_count = '0;
    m_queue_mask = '0;

    directed_rows = '{
      '{0, 0, 0, pets_pkg::CMD_QUERY, 8'd0, 1, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_START, 8'd0, 1, pets_pkg::RC_NOT_INIT},
      '{0, 0, 0, pets_pkg::CMD_STOP, 8'd0, 1, pets_pkg::RC_NOT_RUNNING},
      '{0, 0, 0, pets_pkg::CMD_INIT, 8'd0, 1, pets_pkg::RC_NO_TASKS},
      '{0, 0, 0, pets_pkg::CMD_UNLOCK, 8'd0, 1, pets_pkg::RC_NOT_LOCKED},
      '{0, 0, 0, pets_pkg::CMD_SET_EVENT, 8'd255, 1, pets_pkg::RC_BAD_TASK},
      '{0, 0, 0, pets_pkg::CMD_QUERY, 8'd16, 1, pets_pkg::RC_BAD_TASK},
      '{0, 0, 0, pets_pkg::CMD_TASK_DONE, 8'd128, 1, pets_pkg::RC_BAD_TASK},
      '{0, 0, 0, 4'd15, 8'd0, 1, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_SWITCH, 8'd0, 0, pets_pkg::RC_OK},
      '{1, 8'd255, 16'h0000, pets_pkg::CMD_INIT, 8'd0, 1, pets_pkg::RC_TOO_MANY},
      '{1, 8'd16, 16'hFFFF, pets_pkg::CMD_INIT, 8'd0, 1, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_START, 8'd0, 1, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_START, 8'd0, 1, pets_pkg::RC_RUNNING},
      '{0, 0, 0, pets_pkg::CMD_INIT, 8'd0, 1, pets_pkg::RC_RUNNING},
      '{0, 0, 0, pets_pkg::CMD_SET_EVENT, 8'd15, 0, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_SET_EVENT, 8'd15, 0, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_SWITCH, 8'd0, 0, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_LOCK, 8'd0, 0, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_SET_EVENT, 8'd7, 0, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_UNLOCK, 8'd0, 0, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_TASK_DONE, 8'd15, 0, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_TASK_DONE, 8'd0, 0, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_STOP, 8'd0, 1, pets_pkg::RC_OK},
      '{0, 0, 0, pets_pkg::CMD_SWITCH, 8'd0, 0, pets_pkg::RC_OK}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].do_cfg)
        configure(directed_rows[i].cfg_count, directed_rows[i].cfg_mask);
      send_cmd(directed_rows[i].cmd, directed_rows[i].tsk,
               directed_rows[i].typed, directed_rows[i].rc);
    end

    // random phases: sender-light idling, receiver-light idling, none
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: configure(8'd16, 16'hFFFF);
        1: configure(8'($urandom_range(1, 16)), 16'($urandom));
        default: configure(8'd16, 16'h0000);
      endcase
      sender_idle_pct   = (ph == 0) ? 7 : (ph == 1) ? 63 : 0;
      receiver_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 7 : 0;
      send_cmd(pets_pkg::CMD_INIT, 8'd0);
      send_cmd(pets_pkg::CMD_START, 8'd0);
      // long receiver hold-off with the sender still offering, then push the
      // lock depth past its ceiling and unwind it again
      if (ph == 2) begin
        @(posedge clk);
        rx_hold = 300;
        repeat (257) send_cmd(pets_pkg::CMD_LOCK, pick_task());
        repeat (257) send_cmd(pets_pkg::CMD_UNLOCK, pick_task());
      end
      repeat (250) random_cmd();
    end

    settle();
    $display("Ran %0d commands and checked %0d result beats over three register settings.",
             items_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
